@@ rtl/core/tme_pkg.sv @@
// Package for the transform matrix engine: widths, mode codes, cosine table.
// No dependencies.
package tme_pkg;
  localparam int DataWidth = 16;
  localparam int FracBits  = 8;
  localparam int FieldWidth = 16;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [FieldWidth-1:0] field_t;

  typedef enum logic [3:0] {
    MODE_IDENT  = 4'd0,
    MODE_ROT_X  = 4'd1,
    MODE_ROT_Y  = 4'd2,
    MODE_ROT_Z  = 4'd3,
    MODE_PRE_T  = 4'd4,
    MODE_POST_T = 4'd5,
    MODE_XFORM  = 4'd6,
    MODE_WR_ROW = 4'd7,
    MODE_RD_ROW = 4'd8
  } mode_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;     // capture input word
    logic       trig;     // compute sin and cos
    logic       col_en;   // process one column / row step
    logic [1:0] step;     // column or row index
    logic       finish;   // write result register
  } tme_cmd_t;

  function automatic logic [31:0] cos_const(input logic [2:0] k);
    case (k)
      3'd1: cos_const = 32'd4212440704;
      3'd2: cos_const = 32'd3968032378;
      3'd3: cos_const = 32'd3571134792;
      3'd4: cos_const = 32'd3037000500;
      3'd5: cos_const = 32'd2386155981;
      3'd6: cos_const = 32'd1643612827;
      3'd7: cos_const = 32'd837906553;
      default: cos_const = 32'd0;
    endcase
  endfunction

  // Table entry i (0..8) in fixed point.
  function automatic data_t cos_tbl(input logic [3:0] i);
    logic [31:0] c;
    c = cos_const(i[2:0]);
    if (i == 4'd0) cos_tbl = data_t'(1 << FracBits);
    else if (i >= 4'd8) cos_tbl = '0;
    else cos_tbl = data_t'(c >> (32 - FracBits));
  endfunction

  // Fixed-point product: arithmetic shift, wrap.
  function automatic data_t fmul(input data_t a, input data_t b);
    logic signed [2*DataWidth-1:0] p;
    p = a * b;
    fmul = data_t'(p >>> FracBits);
  endfunction
endpackage

@@ rtl/core/transform_matrix_engine.sv @@
// Top level of the transform matrix engine.
// Depends on tme_pkg, tme_ctrl and tme_dp.
//
// Holds a 4x4 fixed-point matrix (identity after reset) and applies one
// operation per input word: identity, rotate about x/y/z, pre/post
// translate, transform a vector, write a row or read a row.
// Input channel: in_valid_i / in_stall_o with mode, angle, row index and
// four value fields. Output channel: out_valid_o / out_stall_i with four
// result fields; every word yields exactly one result word (zeros for
// modes that return nothing).
// Sequence: capture, sin/cos, one column or row step per matrix column (one
// column of four multiply lanes per cycle), then load of the output register.
// One word in flight at a time; in_stall_o is high while it is worked on.
// If the receiver stalls, the result holds in the output register and the
// engine waits before finishing the next word.
// Reset (rst_ni, asynchronous, active low) restores identity and empties
// the output register.
module transform_matrix_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        mode_i,
  input  tme_pkg::field_t   angle_i,
  input  logic [1:0]        row_index_i,
  input  tme_pkg::field_t   x_value_i,
  input  tme_pkg::field_t   y_value_i,
  input  tme_pkg::field_t   z_value_i,
  input  tme_pkg::field_t   w_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tme_pkg::field_t   result_0_o,
  output tme_pkg::field_t   result_1_o,
  output tme_pkg::field_t   result_2_o,
  output tme_pkg::field_t   result_3_o
);
  import tme_pkg::*;

  tme_cmd_t cmd;

  tme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_valid_i(out_valid_o), .out_stall_i, .cmd_o(cmd)
  );

  tme_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .mode_i, .angle_i, .row_index_i,
    .x_value_i, .y_value_i, .z_value_i, .w_value_i,
    .out_valid_o, .out_stall_i,
    .result_0_o, .result_1_o, .result_2_o, .result_3_o
  );
endmodule

@@ rtl/core/tme_ctrl.sv @@
// Sequencer for the transform matrix engine.
// Depends on tme_pkg.
module tme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  output tme_pkg::tme_cmd_t cmd_o
);
  import tme_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRIG = 4'b0010,
    ST_COL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       out_free;

  assign out_free   = !out_valid_i || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd_o.trig = 1'b1;
        step_d     = 2'd0;
        state_d    = ST_COL;
      end
      ST_COL: begin
        cmd_o.col_en = 1'b1;
        step_d       = step_q + 2'd1;
        if (step_q == 2'd3) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_TRIG) else $error("load out of sequence");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == ST_IDLE) else $error("finish out of sequence");
endmodule

@@ rtl/core/tme_dp.sv @@
// Datapath: matrix store, sin/cos unit, one column (or row) per step.
// Depends on tme_pkg.
module tme_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tme_pkg::tme_cmd_t   cmd_i,
  input  logic [3:0]          mode_i,
  input  tme_pkg::field_t     angle_i,
  input  logic [1:0]          row_index_i,
  input  tme_pkg::field_t     x_value_i,
  input  tme_pkg::field_t     y_value_i,
  input  tme_pkg::field_t     z_value_i,
  input  tme_pkg::field_t     w_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tme_pkg::field_t     result_0_o,
  output tme_pkg::field_t     result_1_o,
  output tme_pkg::field_t     result_2_o,
  output tme_pkg::field_t     result_3_o
);
  import tme_pkg::*;

  localparam int QW = FracBits + 2;

  data_t      m_q [4][4];
  data_t      v_q [4];
  data_t      acc_q [4];
  logic [3:0] mode_q;
  logic [1:0] ri_q;
  data_t      ang_q, sin_q, cos_q;
  logic       vld_q;

  function automatic data_t cos_quad(input logic [FracBits:0] v);
    logic [FracBits+3:0] t;
    logic [3:0]          i;
    data_t               f, a, one;
    one = data_t'(1 << FracBits);
    if (v[FracBits]) return '0;
    t = {v, 3'b000};
    i = t[FracBits+3:FracBits];
    f = data_t'(t[FracBits-1:0]);
    a = cos_tbl(i);
    if (f == '0) return a;
    return fmul(a, one - f) + fmul(cos_tbl(i + 4'd1), f);
  endfunction

  function automatic data_t fcos(input data_t a);
    logic [DataWidth:0] mag;
    logic [QW-1:0]      t;
    logic [FracBits:0]  q;
    logic [QW-1:0]      one;
    one = QW'(1 << FracBits);
    mag = a[DataWidth-1] ? -{a[DataWidth-1], a} : {1'b0, a};
    t   = mag[QW-1:0];
    case (t[QW-1:QW-2])
      2'd0: return cos_quad({1'b0, t[FracBits-1:0]});
      2'd1: begin
        q = (FracBits+1)'((one << 1) - t);
        return -cos_quad(q);
      end
      2'd2: begin
        q = (FracBits+1)'(t - (one << 1));
        return -cos_quad(q);
      end
      default: begin
        q = (FracBits+1)'((one << 2) - t);
        return cos_quad(q);
      end
    endcase
  endfunction

  data_t one_c;
  data_t sa, ca, c_r0, c_r1, c_r2, c_r3;
  data_t k0, k1, k2, k3, pre0, pre1, pre2;
  data_t rowsum;
  logic [1:0] s;
  logic [1:0] rp, rq;

  assign one_c = data_t'(1 << FracBits);
  assign s = cmd_i.step;

  always_comb begin
    case (mode_q)
      MODE_ROT_X: begin rp = 2'd1; rq = 2'd2; end
      MODE_ROT_Y: begin rp = 2'd2; rq = 2'd0; end
      default:    begin rp = 2'd0; rq = 2'd1; end
    endcase
    c_r0 = m_q[0][s];
    c_r1 = m_q[1][s];
    c_r2 = m_q[2][s];
    c_r3 = m_q[3][s];
    ca = fmul(cos_q, m_q[rp][s]) - fmul(sin_q, m_q[rq][s]);
    sa = fmul(sin_q, m_q[rp][s]) + fmul(cos_q, m_q[rq][s]);
    pre0 = c_r0 + fmul(v_q[0], c_r3);
    pre1 = c_r1 + fmul(v_q[1], c_r3);
    pre2 = c_r2 + fmul(v_q[2], c_r3);
    // row s: products with v; columns 2,1,0 summed for post-translate, all four for transform
    k2 = fmul(m_q[s][2], v_q[2]);
    k1 = fmul(m_q[s][1], v_q[1]);
    k0 = fmul(m_q[s][0], v_q[0]);
    k3 = fmul(m_q[s][3], v_q[3]);
    rowsum = k0 + k1 + k2 + k3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++)
          m_q[r][k] <= (r == k) ? one_c : '0;
      vld_q <= 1'b0;
    end else begin
      // new word in, or hold until the receiver takes it
      vld_q <= cmd_i.finish | (vld_q & out_stall_i);
      if (cmd_i.load && mode_i == MODE_IDENT) begin
        for (int r = 0; r < 4; r++)
          for (int k = 0; k < 4; k++)
            m_q[r][k] <= (r == k) ? one_c : '0;
      end
      if (cmd_i.col_en) begin
        case (mode_q)
          MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: begin
            m_q[rp][s] <= ca;
            m_q[rq][s] <= sa;
          end
          MODE_PRE_T: begin
            m_q[0][s] <= pre0;
            m_q[1][s] <= pre1;
            m_q[2][s] <= pre2;
          end
          MODE_POST_T: m_q[s][3] <= m_q[s][3] + (k0 + k1 + k2);
          MODE_WR_ROW: m_q[ri_q][s] <= v_q[s];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      ri_q   <= row_index_i;
      ang_q  <= data_t'(angle_i);
      v_q[0] <= data_t'(x_value_i);
      v_q[1] <= data_t'(y_value_i);
      v_q[2] <= data_t'(z_value_i);
      v_q[3] <= data_t'(w_value_i);
      for (int k = 0; k < 4; k++) acc_q[k] <= '0;
    end
    if (cmd_i.trig) begin
      cos_q <= fcos(ang_q);
      sin_q <= fcos(ang_q - one_c);
    end
    if (cmd_i.col_en) begin
      if (mode_q == MODE_XFORM) acc_q[s] <= rowsum;
      if (mode_q == MODE_RD_ROW) acc_q[s] <= m_q[ri_q][s];
    end
    if (cmd_i.finish) begin
      result_0_o <= field_t'(acc_q[0]);
      result_1_o <= field_t'(acc_q[1]);
      result_2_o <= field_t'(acc_q[2]);
      result_3_o <= field_t'(acc_q[3]);
    end
  end

  assign out_valid_o = vld_q;
endmodule
